>>> src/swbm_pkg.sv
// Package for the two-wire sensor bus master: phase codes, command codes,
// state and item types, and the segment length table.
// No dependencies.
package swbm_pkg;

    localparam int RESET_CLOCKS_DEF = 9;
    localparam logic [15:0] UNIT_TICKS_RST = 16'd1000;
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // command codes on the mode field
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_CRST  = 3'd1;
    localparam logic [2:0] MODE_START = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;
    localparam logic [2:0] MODE_WAIT  = 3'd5;

    // bus schedule phases
    localparam logic [4:0] PH_IDLE        = 5'd0;
    localparam logic [4:0] PH_RST_HI      = 5'd1;
    localparam logic [4:0] PH_RST_LO      = 5'd2;
    localparam logic [4:0] PH_ST_A        = 5'd3;
    localparam logic [4:0] PH_ST_B        = 5'd4;
    localparam logic [4:0] PH_ST_C        = 5'd5;
    localparam logic [4:0] PH_ST_D        = 5'd6;
    localparam logic [4:0] PH_ST_E        = 5'd7;
    localparam logic [4:0] PH_ST_F        = 5'd8;
    localparam logic [4:0] PH_WR_SETUP    = 5'd9;
    localparam logic [4:0] PH_WR_HIGH     = 5'd10;
    localparam logic [4:0] PH_WR_HOLD     = 5'd11;
    localparam logic [4:0] PH_WR_ACKSETUP = 5'd12;
    localparam logic [4:0] PH_WR_ACKHIGH  = 5'd13;
    localparam logic [4:0] PH_RD_LOW      = 5'd14;
    localparam logic [4:0] PH_RD_HIGH     = 5'd15;
    localparam logic [4:0] PH_RD_ACKSETUP = 5'd16;
    localparam logic [4:0] PH_RD_ACKHIGH  = 5'd17;
    localparam logic [4:0] PH_RD_ACKHOLD  = 5'd18;
    localparam logic [4:0] PH_WT_DELAY    = 5'd19;
    localparam logic [4:0] PH_WT_POLL     = 5'd20;
    localparam logic [4:0] PH_COUNT       = 5'd21;

    typedef struct packed {
        logic [4:0]  phase;
        logic [3:0]  bit_count;
        logic [2:0]  unit_count;
        logic [15:0] tick_count;
        logic [7:0]  shift_reg;
        logic        sck_level;
        logic        data_out;
        logic        ack_wanted;
        logic        ack_error;
        logic [7:0]  rx_hold;
    } swbm_state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       data_level;
    } swbm_item_t;

    localparam swbm_state_t STATE_RST = '{
        phase:      PH_IDLE,
        bit_count:  4'd0,
        unit_count: 3'd0,
        tick_count: 16'd0,
        shift_reg:  8'd0,
        sck_level:  1'b0,
        data_out:   1'b1,
        ack_wanted: 1'b0,
        ack_error:  1'b0,
        rx_hold:    8'd0
    };

    // units per segment
    function automatic logic [2:0] seg_units(input logic [4:0] ph);
        logic [2:0] u;
        unique case (ph)
            PH_ST_D, PH_WR_HIGH, PH_RD_LOW, PH_RD_HIGH, PH_RD_ACKHIGH: u = 3'd3;
            PH_WR_ACKHIGH, PH_RD_ACKSETUP:                             u = 3'd2;
            PH_WT_DELAY:                                               u = 3'd5;
            PH_IDLE, PH_WT_POLL:                                       u = 3'd0;
            default:                                                   u = 3'd1;
        endcase
        return u;
    endfunction

endpackage

>>> src/swbm_step.sv
// One tick of the bus schedule: next state and done flag from the current
// state, one input item and the unit length. Pure combinational.
// Depends on swbm_pkg.
module swbm_step #(
    parameter int RESET_CLOCKS = swbm_pkg::RESET_CLOCKS_DEF
) (
    input  swbm_pkg::swbm_state_t st,
    input  swbm_pkg::swbm_item_t  item,
    input  logic [15:0]           unit_ticks,
    output swbm_pkg::swbm_state_t ns,
    output logic                  done
);
    import swbm_pkg::*;

    localparam logic [3:0] RST_LIM = 4'(RESET_CLOCKS);

    logic [15:0] ut;
    logic [15:0] tick_inc;
    logic [2:0]  unit_inc;
    logic [3:0]  bit_inc;

    // entering a segment restarts the counters and sets the line levels
    function automatic swbm_state_t enter_seg(input swbm_state_t s, input logic [4:0] p);
        swbm_state_t r;
        r = s;
        r.phase = p;
        r.unit_count = 3'd0;
        r.tick_count = 16'd0;
        unique case (p)
            PH_RST_HI:      begin r.data_out = 1'b1; r.sck_level = 1'b1; end
            PH_RST_LO:      r.sck_level = 1'b0;
            PH_ST_A:        begin r.data_out = 1'b1; r.sck_level = 1'b0; end
            PH_ST_B:        r.sck_level = 1'b1;
            PH_ST_C:        r.data_out = 1'b0;
            PH_ST_D:        r.sck_level = 1'b0;
            PH_ST_E:        r.sck_level = 1'b1;
            PH_ST_F:        r.data_out = 1'b1;
            PH_WR_SETUP:    begin r.data_out = s.shift_reg[7]; r.sck_level = 1'b0; end
            PH_WR_HIGH:     r.sck_level = 1'b1;
            PH_WR_HOLD:     r.sck_level = 1'b0;
            PH_WR_ACKSETUP: begin r.data_out = 1'b1; r.sck_level = 1'b0; end
            PH_WR_ACKHIGH:  r.sck_level = 1'b1;
            PH_RD_LOW:      begin r.data_out = 1'b1; r.sck_level = 1'b0; end
            PH_RD_HIGH:     r.sck_level = 1'b1;
            PH_RD_ACKSETUP: begin r.data_out = ~s.ack_wanted; r.sck_level = 1'b0; end
            PH_RD_ACKHIGH:  r.sck_level = 1'b1;
            PH_RD_ACKHOLD:  r.sck_level = 1'b0;
            PH_WT_POLL:     r.data_out = 1'b1;
            default:        ;
        endcase
        return r;
    endfunction

    assign ut       = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;
    assign tick_inc = st.tick_count + 16'd1;
    assign unit_inc = st.unit_count + 3'd1;
    assign bit_inc  = st.bit_count + 4'd1;

    always_comb
    begin
        ns   = st;
        done = 1'b0;
        if (st.phase == PH_IDLE)
        begin
            ns.bit_count = 4'd0;
            unique case (item.mode)
                MODE_CRST:  ns = enter_seg(ns, PH_RST_HI);
                MODE_START: ns = enter_seg(ns, PH_ST_A);
                MODE_WRITE:
                begin
                    ns.shift_reg = item.tx_byte;
                    ns = enter_seg(ns, PH_WR_SETUP);
                end
                MODE_READ:
                begin
                    ns.ack_wanted = item.send_ack;
                    ns.shift_reg  = 8'd0;
                    ns = enter_seg(ns, PH_RD_LOW);
                end
                MODE_WAIT:  ns = enter_seg(ns, PH_WT_DELAY);
                default:    ns.bit_count = st.bit_count;  // tick only
            endcase
        end
        else if (st.phase == PH_WT_POLL)
        begin
            if (!item.data_level)
            begin
                ns.phase = PH_IDLE;
                done     = 1'b1;
            end
        end
        else if (st.phase < PH_COUNT)
        begin
            ns.tick_count = tick_inc;
            if (tick_inc >= ut)
            begin
                ns.tick_count = 16'd0;
                ns.unit_count = unit_inc;
                if (unit_inc >= seg_units(st.phase))
                begin
                    unique case (st.phase)
                        PH_RST_LO:
                        begin
                            ns.bit_count = bit_inc;
                            ns = enter_seg(ns, (bit_inc < RST_LIM) ? PH_RST_HI : PH_ST_A);
                        end
                        PH_ST_F:
                        begin
                            ns.sck_level = 1'b0;
                            ns.phase     = PH_IDLE;
                            done         = 1'b1;
                        end
                        PH_WR_HOLD:
                        begin
                            ns.bit_count = bit_inc;
                            if (bit_inc < BYTE_BITS)
                            begin
                                ns.shift_reg = {st.shift_reg[6:0], 1'b0};
                                ns = enter_seg(ns, PH_WR_SETUP);
                            end
                            else
                            begin
                                ns = enter_seg(ns, PH_WR_ACKSETUP);
                            end
                        end
                        PH_WR_ACKHIGH:
                        begin
                            ns.ack_error = item.data_level;
                            ns.sck_level = 1'b0;
                            ns.phase     = PH_IDLE;
                            done         = 1'b1;
                        end
                        PH_RD_LOW:
                        begin
                            ns.shift_reg = {st.shift_reg[6:0], item.data_level};
                            ns = enter_seg(ns, PH_RD_HIGH);
                        end
                        PH_RD_HIGH:
                        begin
                            ns.bit_count = bit_inc;
                            ns = enter_seg(ns,
                                (bit_inc < BYTE_BITS) ? PH_RD_LOW : PH_RD_ACKSETUP);
                        end
                        PH_RD_ACKHOLD:
                        begin
                            ns.rx_hold  = st.shift_reg;
                            ns.data_out = 1'b1;
                            ns.phase    = PH_IDLE;
                            done        = 1'b1;
                        end
                        PH_WT_DELAY: ns = enter_seg(ns, PH_WT_POLL);
                        default:
                        begin
                            if ((st.phase + 5'd1) < PH_COUNT)
                                ns = enter_seg(ns, st.phase + 5'd1);
                            else
                                ns.phase = PH_IDLE;
                        end
                    endcase
                end
            end
        end
        else
        begin
            ns.phase = PH_IDLE;
        end
    end

endmodule

>>> src/sensor_two_wire_bus_master_core.sv
// Two-wire sensor bus master, one timing tick per input beat.
// An input beat goes to the input register, then the result register holds
// the levels after that tick. Throughput: one beat per cycle while out_stall
// is low; the schedule state updates once per beat. Reset: schedule idle
// with its line released and clock low, unit length 1000 ticks.
// Depends on swbm_pkg and swbm_step.
module sensor_two_wire_bus_master_core #(
    parameter int RESET_CLOCKS = swbm_pkg::RESET_CLOCKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  tx_byte,
    input  logic        send_ack,
    input  logic        data_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        sck,
    output logic        data_release,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  rx_byte,
    output logic        ack_missing
);
    import swbm_pkg::*;

    logic [15:0] unit_ticks_reg;
    logic        in_valid_reg;
    swbm_item_t  item_reg;
    swbm_state_t state_reg;
    swbm_state_t state_next;
    logic        done_next;
    logic        out_valid_reg;
    logic        sck_reg;
    logic        data_rel_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [7:0]  rx_reg;
    logic        ack_miss_reg;
    logic        advance;
    logic        in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    swbm_step #(
        .RESET_CLOCKS(RESET_CLOCKS)
    ) u_step (
        .st        (state_reg),
        .item      (item_reg),
        .unit_ticks(unit_ticks_reg),
        .ns        (state_next),
        .done      (done_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_ticks_reg <= UNIT_TICKS_RST;
        else if (cfg_wr_en)
            unit_ticks_reg <= cfg_wr_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= '{mode: mode, tx_byte: tx_byte, send_ack: send_ack,
                          data_level: data_level};
    end

    // schedule state moves one tick per processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RST;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sck_reg      <= state_next.sck_level;
            data_rel_reg <= state_next.data_out;
            busy_reg     <= (state_next.phase != PH_IDLE);
            done_reg     <= done_next;
            rx_reg       <= state_next.rx_hold;
            ack_miss_reg <= state_next.ack_error;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sck          = sck_reg;
    assign data_release = data_rel_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign rx_byte      = rx_reg;
    assign ack_missing  = ack_miss_reg;

    // every sequence ends with the clock low and the data line released
    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE |-> !state_reg.sck_level && state_reg.data_out)
        else $error("idle with bus lines not at rest");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase < PH_COUNT)
        else $error("schedule phase out of range");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done beat reported busy");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with result register empty");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(state_reg))
        else $error("schedule state moved without a beat");

endmodule

>>> dv/swbm_bus_checker.sv
// Checker for the two-wire sensor bus master: predicts the bus levels for every
// accepted input beat and compares each result beat against them in order.
// Depends on swbm_pkg for the phase, command and state definitions.
module swbm_bus_checker #(
    parameter int RESET_CLOCKS = swbm_pkg::RESET_CLOCKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  tx_byte,
    input  logic        send_ack,
    input  logic        data_level,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        sck,
    input  logic        data_release,
    input  logic        busy_res,
    input  logic        done_res,
    input  logic [7:0]  rx_byte,
    input  logic        ack_missing,
    input  logic        end_check,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import swbm_pkg::*;

    localparam logic [3:0] RST_LIM = 4'(RESET_CLOCKS);

    typedef struct packed {
        logic       sck;
        logic       rel;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack_miss;
    } bus_levels_t;

    swbm_state_t  bus_st;
    logic [15:0]  unit_len;
    bus_levels_t  levels_q[$];
    bit           end_seen;
    int           fails = 0;

    assign fail_count = fails;

    task automatic report_mismatch(input string what, input logic [7:0] want_v,
                                   input logic [7:0] got_v);
        $display("%0t ns: %s mismatch, expected %0h got %0h", $time, what, want_v, got_v);
        fails++;
    endtask

    // length of each bus segment in delay units
    function automatic logic [2:0] seg_len_of(input logic [4:0] ph);
        logic [2:0] n;
        case (ph)
            PH_WT_DELAY:                                 n = 3'd5;
            PH_ST_D, PH_WR_HIGH, PH_RD_ACKHIGH:          n = 3'd3;
            PH_RD_LOW, PH_RD_HIGH:                       n = 3'd3;
            PH_WR_ACKHIGH, PH_RD_ACKSETUP:               n = 3'd2;
            PH_IDLE, PH_WT_POLL:                         n = 3'd0;
            default:                                     n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic void open_seg(input logic [4:0] ph);
        bus_st.phase      = ph;
        bus_st.unit_count = '0;
        bus_st.tick_count = '0;
        case (ph)
            PH_RST_HI:
            begin
                bus_st.data_out  = 1'b1;
                bus_st.sck_level = 1'b1;
            end
            PH_ST_A, PH_WR_ACKSETUP, PH_RD_LOW:
            begin
                bus_st.data_out  = 1'b1;
                bus_st.sck_level = 1'b0;
            end
            PH_RST_LO, PH_ST_D, PH_WR_HOLD, PH_RD_ACKHOLD:
                bus_st.sck_level = 1'b0;
            PH_ST_B, PH_ST_E, PH_WR_HIGH, PH_WR_ACKHIGH, PH_RD_HIGH, PH_RD_ACKHIGH:
                bus_st.sck_level = 1'b1;
            PH_ST_C:
                bus_st.data_out = 1'b0;
            PH_ST_F, PH_WT_POLL:
                bus_st.data_out = 1'b1;
            PH_WR_SETUP:
            begin
                bus_st.data_out  = bus_st.shift_reg[7];
                bus_st.sck_level = 1'b0;
            end
            PH_RD_ACKSETUP:
            begin
                bus_st.data_out  = !bus_st.ack_wanted;
                bus_st.sck_level = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // end of a segment; returns 1 when the whole sequence is complete
    function automatic logic close_seg(input logic din);
        logic fin;
        fin = 1'b0;
        case (bus_st.phase)
            PH_RST_LO:
            begin
                bus_st.bit_count = bus_st.bit_count + 4'd1;
                open_seg(bus_st.bit_count < RST_LIM ? PH_RST_HI : PH_ST_A);
            end
            PH_ST_F:
            begin
                bus_st.sck_level = 1'b0;
                bus_st.phase     = PH_IDLE;
                fin              = 1'b1;
            end
            PH_WR_HOLD:
            begin
                bus_st.bit_count = bus_st.bit_count + 4'd1;
                if (bus_st.bit_count < BYTE_BITS)
                begin
                    bus_st.shift_reg = bus_st.shift_reg << 1;
                    open_seg(PH_WR_SETUP);
                end
                else
                    open_seg(PH_WR_ACKSETUP);
            end
            PH_WR_ACKHIGH:
            begin
                bus_st.ack_error = din;
                bus_st.sck_level = 1'b0;
                bus_st.phase     = PH_IDLE;
                fin              = 1'b1;
            end
            PH_RD_LOW:
            begin
                bus_st.shift_reg = {bus_st.shift_reg[6:0], din};
                open_seg(PH_RD_HIGH);
            end
            PH_RD_HIGH:
            begin
                bus_st.bit_count = bus_st.bit_count + 4'd1;
                open_seg(bus_st.bit_count < BYTE_BITS ? PH_RD_LOW : PH_RD_ACKSETUP);
            end
            PH_RD_ACKHOLD:
            begin
                bus_st.rx_hold  = bus_st.shift_reg;
                bus_st.data_out = 1'b1;
                bus_st.phase    = PH_IDLE;
                fin             = 1'b1;
            end
            PH_WT_DELAY:
                open_seg(PH_WT_POLL);
            default:
                if (bus_st.phase < PH_COUNT - 5'd1)
                    open_seg(bus_st.phase + 5'd1);
                else
                    bus_st.phase = PH_IDLE;
        endcase
        return fin;
    endfunction

    function automatic bus_levels_t advance_tick(input swbm_item_t it);
        logic [15:0] len;
        logic        fin;
        bus_levels_t r;
        len = (unit_len == 16'd0) ? 16'd1 : unit_len;
        fin = 1'b0;
        if (bus_st.phase == PH_IDLE)
        begin
            // commands are only taken while idle; spare codes are plain ticks
            if (it.mode >= MODE_CRST && it.mode <= MODE_WAIT)
            begin
                bus_st.bit_count = '0;
                case (it.mode)
                    MODE_CRST:  open_seg(PH_RST_HI);
                    MODE_START: open_seg(PH_ST_A);
                    MODE_WRITE:
                    begin
                        bus_st.shift_reg = it.tx_byte;
                        open_seg(PH_WR_SETUP);
                    end
                    MODE_READ:
                    begin
                        bus_st.ack_wanted = it.send_ack;
                        bus_st.shift_reg  = '0;
                        open_seg(PH_RD_LOW);
                    end
                    default:    open_seg(PH_WT_DELAY);
                endcase
            end
        end
        else if (bus_st.phase == PH_WT_POLL)
        begin
            if (!it.data_level)
            begin
                bus_st.phase = PH_IDLE;
                fin          = 1'b1;
            end
        end
        else if (bus_st.phase < PH_COUNT)
        begin
            bus_st.tick_count = bus_st.tick_count + 16'd1;
            if (bus_st.tick_count >= len)
            begin
                bus_st.tick_count = '0;
                bus_st.unit_count = bus_st.unit_count + 3'd1;
                if (bus_st.unit_count >= seg_len_of(bus_st.phase))
                    fin = close_seg(it.data_level);
            end
        end
        else
            bus_st.phase = PH_IDLE;

        r.sck      = bus_st.sck_level;
        r.rel      = bus_st.data_out;
        r.busy     = (bus_st.phase != PH_IDLE);
        r.done     = fin;
        r.rx       = bus_st.rx_hold;
        r.ack_miss = bus_st.ack_error;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        swbm_item_t  it;
        bus_levels_t want;
        if (!rst_n)
        begin
            bus_st   = STATE_RST;
            unit_len = UNIT_TICKS_RST;
            levels_q.delete();
            end_seen = 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                unit_len = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                it.mode       = mode;
                it.tx_byte    = tx_byte;
                it.send_ack   = send_ack;
                it.data_level = data_level;
                levels_q.push_back(advance_tick(it));
            end
            if (out_valid && !out_stall)
            begin
                if (levels_q.size() == 0)
                    report_mismatch("unexpected result beat", 8'h00, 8'h01);
                else
                begin
                    want = levels_q.pop_front();
                    if (sck !== want.sck)
                        report_mismatch("sck", 8'(want.sck), 8'(sck));
                    if (data_release !== want.rel)
                        report_mismatch("data_release", 8'(want.rel), 8'(data_release));
                    if (busy_res !== want.busy)
                        report_mismatch("busy_res", 8'(want.busy), 8'(busy_res));
                    if (done_res !== want.done)
                        report_mismatch("done_res", 8'(want.done), 8'(done_res));
                    if (rx_byte !== want.rx)
                        report_mismatch("rx_byte", want.rx, rx_byte);
                    if (ack_missing !== want.ack_miss)
                        report_mismatch("ack_missing", 8'(want.ack_miss), 8'(ack_missing));
                end
            end
            if (end_check && !end_seen)
            begin
                end_seen = 1'b1;
                if (levels_q.size() != 0)
                    report_mismatch("results never delivered", 8'h00,
                                    8'(levels_q.size()));
            end
        end
    end

endmodule

>>> dv/tb_sensor_two_wire_bus_master_core.sv
// Top of the bus master testbench: clock, reset, bus command stimulus, random
// idling on both channels, and the verdict. Prediction lives in swbm_bus_checker.
// Depends on swbm_pkg, swbm_bus_checker and sensor_two_wire_bus_master_core.
module tb_sensor_two_wire_bus_master_core;
    timeunit 1ns;
    timeprecision 1ps;

    import swbm_pkg::*;

    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    // ticks after the command beat, in delay units, until done (wait: to polling)
    localparam int START_UNITS = 8;
    localparam int CRST_UNITS  = 2 * RESET_CLOCKS_DEF + START_UNITS;
    localparam int WRITE_UNITS = 43;
    localparam int READ_UNITS  = 54;
    localparam int WAIT_UNITS  = 5;

    localparam int DL_RANDOM = 0;
    localparam int DL_LOW    = 1;
    localparam int DL_HIGH   = 2;

    localparam int IDLE_NONE  = 0;
    localparam int IDLE_LIGHT = 1;
    localparam int IDLE_FULL  = 2;

    localparam int HOLD_CYCLES = 200;
    localparam int ITEM_TARGET = 450;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [15:0] cfg_wr_data  = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [2:0]  mode         = MODE_TICK;
    logic [7:0]  tx_byte      = '0;
    logic        send_ack     = 1'b0;
    logic        data_level   = 1'b1;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        sck;
    logic        data_release;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        ack_missing;
    logic        end_check    = 1'b0;
    int          fail_count;

    int          sent_cnt    = 0;
    int          recv_cnt    = 0;
    int          hold_reqs   = 0;
    int          hold_served = 0;
    int          tx_idle     = IDLE_NONE;
    int          rx_idle     = IDLE_NONE;
    int          cur_len     = UNIT_TICKS_RST;

    sensor_two_wire_bus_master_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .tx_byte      (tx_byte),
        .send_ack     (send_ack),
        .data_level   (data_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sck          (sck),
        .data_release (data_release),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rx_byte      (rx_byte),
        .ack_missing  (ack_missing)
    );

    swbm_bus_checker bus_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .tx_byte      (tx_byte),
        .send_ack     (send_ack),
        .data_level   (data_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sck          (sck),
        .data_release (data_release),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .rx_byte      (rx_byte),
        .ack_missing  (ack_missing),
        .end_check    (end_check),
        .fail_count   (fail_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #1ms;
        $display("simulation failed");
        $finish;
    end

    function automatic int draw_gap(input int style);
        int g;
        case (style)
            IDLE_LIGHT: g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            IDLE_FULL:  g = $urandom_range(0, 19);
            default:    g = 0;
        endcase
        return g;
    endfunction

    function automatic logic pick_level(input int pat);
        logic v;
        case (pat)
            DL_LOW:  v = 1'b0;
            DL_HIGH: v = 1'b1;
            default: v = 1'($urandom_range(0, 1));
        endcase
        return v;
    endfunction

    // result side: random stall per beat, plus the occasional long hold-off
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(rx_idle);
            if (hold_served != hold_reqs)
            begin
                hold_served = hold_reqs;
                gap         = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            recv_cnt++;
        end
    end

    task automatic push_beat(input logic [2:0] m, input logic [7:0] b, input logic a,
                             input logic d);
        int gap;
        gap = draw_gap(tx_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        tx_byte    <= b;
        send_ack   <= a;
        data_level <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_cnt++;
    endtask

    // tick beat with random command fields
    task automatic push_filler(input logic d);
        push_beat(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), d);
    endtask

    // command beat, then exactly enough ticks for the sequence to complete;
    // the ticks carry random codes, which the block must ignore while busy
    task automatic run_command(input logic [2:0] m, input logic [7:0] b, input logic a,
                               input int pat, input int poll_ones);
        int units;
        case (m)
            MODE_CRST:  units = CRST_UNITS;
            MODE_START: units = START_UNITS;
            MODE_WRITE: units = WRITE_UNITS;
            MODE_READ:  units = READ_UNITS;
            MODE_WAIT:  units = WAIT_UNITS;
            default:    units = 0;
        endcase
        push_beat(m, b, a, pick_level(pat));
        repeat (units * cur_len)
            push_filler(pick_level(pat));
        if (m == MODE_WAIT)
        begin
            repeat (poll_ones)
                push_filler(1'b1);
            push_filler(1'b0);
        end
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (recv_cnt != sent_cnt) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_unit_len(input logic [15:0] v);
        quiesce();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_len = (v == 16'd0) ? 1 : v;
    endtask

    initial
    begin
        logic [2:0]  m;
        int          pat;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset unit length: a start stays in its first segment
        push_beat(MODE_START, 8'h00, 1'b0, 1'b1);
        repeat (12)
            push_filler(1'($urandom_range(0, 1)));

        // one tick per unit from here, the pending start runs out
        set_unit_len(16'd1);
        repeat (START_UNITS)
            push_filler(1'($urandom_range(0, 1)));

        tx_idle = IDLE_LIGHT;
        rx_idle = IDLE_LIGHT;
        run_command(MODE_CRST, 8'h00, 1'b0, DL_RANDOM, 0);
        run_command(MODE_START, 8'hFF, 1'b1, DL_RANDOM, 0);
        run_command(MODE_WRITE, 8'hA5, 1'b0, DL_RANDOM, 0);
        run_command(MODE_READ, 8'h5A, 1'b1, DL_RANDOM, 0);
        run_command(MODE_WAIT, 8'h00, 1'b0, DL_LOW, 0);
        run_command(MODE_WAIT, 8'h00, 1'b0, DL_HIGH, 3);
        run_command(MODE_SPARE6, 8'hFF, 1'b1, DL_LOW, 0);
        run_command(MODE_SPARE7, 8'h00, 1'b0, DL_HIGH, 0);
        run_command(MODE_TICK, 8'hFF, 1'b1, DL_RANDOM, 0);

        // zero length behaves as a single tick
        set_unit_len(16'd0);
        run_command(MODE_START, 8'h00, 1'b0, DL_RANDOM, 0);
        set_unit_len(16'd2);
        tx_idle = IDLE_FULL;
        rx_idle = IDLE_FULL;
        run_command(MODE_START, 8'h00, 1'b0, DL_RANDOM, 0);

        // result side holds off while beats keep coming, so the block backs up
        set_unit_len(16'd1);
        tx_idle = IDLE_NONE;
        hold_reqs++;
        run_command(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    DL_RANDOM, 0);

        while (sent_cnt < ITEM_TARGET - 60)
        begin
            set_unit_len(16'($urandom_range(0, 1)));
            tx_idle = $urandom_range(IDLE_NONE, IDLE_FULL);
            rx_idle = $urandom_range(IDLE_NONE, IDLE_FULL);
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       m = MODE_TICK;
                    1:       m = MODE_SPARE6;
                    default: m = MODE_SPARE7;
                endcase
                pat = DL_RANDOM;
            end
            else
            begin
                m   = 3'($urandom_range(MODE_CRST, MODE_WAIT));
                pat = ($urandom_range(0, 5) == 0) ? $urandom_range(DL_LOW, DL_HIGH)
                                                  : DL_RANDOM;
            end
            run_command(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), pat,
                        $urandom_range(0, 8));
        end

        // longest unit: the sequence cannot finish, so only its start is watched
        set_unit_len(16'hFFFF);
        tx_idle = IDLE_LIGHT;
        rx_idle = IDLE_LIGHT;
        run_command(MODE_SPARE7, 8'hFF, 1'b1, DL_RANDOM, 0);
        push_beat(MODE_START, 8'h00, 1'b0, 1'b1);
        repeat (20)
            push_filler(1'($urandom_range(0, 1)));

        quiesce();
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
src/swbm_pkg.sv
src/swbm_step.sv
src/sensor_two_wire_bus_master_core.sv
dv/swbm_bus_checker.sv
dv/tb_sensor_two_wire_bus_master_core.sv
